### src/triggered_click_sample_mixer_top_macros.svh
`ifndef TRIGGERED_CLICK_SAMPLE_MIXER_TOP_MACROS_SVH
`define TRIGGERED_CLICK_SAMPLE_MIXER_TOP_MACROS_SVH

// Checks are clocked on aclk and disabled while aresetn is low.
`define TCSM_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("tcsm: same-cycle check failed");

`define TCSM_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("tcsm: next-cycle check failed");

`endif

### src/tcsm_pkg.sv
package tcsm_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_LED   = 2'd1,
        CMD_MIX   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ENABLED       = 2'd0,
        CFG_VOLUME        = 2'd1,
        CFG_SAMPLE_LENGTH = 2'd2
    } cfg_index_t;

    localparam logic signed [19:0] SAT_MAX   = 20'sd32767;
    localparam logic signed [19:0] SAT_MIN   = -20'sd32768;
    localparam int                 VOL_SHIFT = 8;

    localparam logic       ENABLED_RESET = 1'b1;
    localparam logic [8:0] VOLUME_RESET  = 9'd200;
    localparam logic [12:0] LENGTH_RESET = 13'd0;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        sample_index;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic               led_a;
        logic               led_b;
        logic signed [15:0] audio_left;
        logic signed [15:0] audio_right;
    } in_item_t;

endpackage

### src/tcsm_store.sv
module tcsm_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [31:0]   rd_data_a,
    output logic [31:0]   rd_data_b
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A write in the same cycle as the read is forwarded to the read data.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == rd_addr_a) begin
            rd_a_reg <= wr_data;
        end else begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && wr_addr == rd_addr_b) begin
            rd_b_reg <= wr_data;
        end else begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### src/tcsm_voice.sv
module tcsm_voice
    import tcsm_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic               run,
    input  logic [8:0]         volume,
    input  logic [AW:0]        len,
    input  logic               active_in,
    input  logic [AW-1:0]      pos_in,
    input  logic [31:0]        frame,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               active_out,
    output logic [AW-1:0]      pos_out
);

    function automatic logic signed [15:0] add_sat(logic signed [15:0] a,
                                                   logic signed [17:0] b);
        logic signed [19:0] sum;
        sum = {{4{a[15]}}, a} + {{2{b[17]}}, b};
        if (sum > SAT_MAX) begin
            return SAT_MAX[15:0];
        end else if (sum < SAT_MIN) begin
            return SAT_MIN[15:0];
        end
        return sum[15:0];
    endfunction

    logic signed [15:0] smp_l;
    logic signed [15:0] smp_r;
    logic signed [9:0]  gain;
    logic signed [25:0] prod_l;
    logic signed [25:0] prod_r;
    logic signed [17:0] scaled_l;
    logic signed [17:0] scaled_r;
    logic               hit;
    logic [AW:0]        pos_ext;
    logic [AW:0]        pos_after;

    assign smp_l    = frame[15:0];
    assign smp_r    = frame[31:16];
    assign gain     = signed'({1'b0, volume});
    assign prod_l   = smp_l * gain;
    assign prod_r   = smp_r * gain;
    assign scaled_l = prod_l[VOL_SHIFT +: 18];
    assign scaled_r = prod_r[VOL_SHIFT +: 18];

    assign pos_ext   = {1'b0, pos_in};
    assign hit       = pos_ext < len;
    assign pos_after = hit ? pos_ext + 1'b1 : pos_ext;

    always_comb begin
        left_out   = left_in;
        right_out  = right_in;
        active_out = active_in;
        pos_out    = pos_in;
        if (run && active_in) begin
            if (hit) begin
                left_out  = add_sat(left_in, scaled_l);
                right_out = add_sat(right_in, scaled_r);
            end
            if (pos_after >= len) begin
                active_out = 1'b0;
                pos_out    = '0;
            end else begin
                pos_out = pos_after[AW-1:0];
            end
        end
    end

endmodule

### src/triggered_click_sample_mixer_top.sv
// Two-voice click mixer for a stereo audio stream. Requests on the s_ channel
// carry a command in s_tuser: sample writes fill the click store, LED updates
// start a drive's voice on a rising LED edge, and mix requests return one
// stereo frame on the m_ channel with the active voices added and saturated.
// The block takes one request per cycle unless m_tready stalls a mix. Each
// request is held in in_reg, its result in the output registers. The click
// store is read at the next positions of both voices, so voice update and
// mix complete in a single stage. Writes and LED updates produce no result.
`include "triggered_click_sample_mixer_top_macros.svh"

module triggered_click_sample_mixer_top
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_index, sample_left, sample_right, led_a, led_b, audio_left,
    // audio_right, two zero bits
    input  logic [79:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_left, out_right, voice_a_busy, voice_b_busy, six zero bits
    output logic [39:0] m_tdata
);

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    logic        enabled_reg;
    logic [8:0]  volume_reg;
    logic [12:0] length_reg;

    in_item_t in_reg;
    logic     v1_reg;

    logic          act_a_reg, act_b_reg, act_a_next, act_b_next;
    logic [AW-1:0] pos_a_reg, pos_b_reg, pos_a_next, pos_b_next;
    logic          prev_a_reg, prev_b_reg;

    logic               ov_reg;
    logic signed [15:0] out_l_reg, out_r_reg;
    logic               busy_a_reg, busy_b_reg;

    logic        adv;
    logic        mix_go;
    logic        led_go;
    logic        run;
    logic        wr_en;
    logic [AW:0] len;
    logic [31:0] frame_a, frame_b;

    logic signed [15:0] l_mid, r_mid, l_fin, r_fin;
    logic               act_a_mix, act_b_mix;
    logic [AW-1:0]      pos_a_mix, pos_b_mix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= ENABLED_RESET;
            volume_reg  <= VOLUME_RESET;
            length_reg  <= LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLED:       enabled_reg <= cfg_data[0];
                CFG_VOLUME:        volume_reg  <= cfg_data[8:0];
                CFG_SAMPLE_LENGTH: length_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = v1_reg && (in_reg.cmd != CMD_MIX || !ov_reg || m_tready);
    assign s_tready = !v1_reg || adv;
    assign mix_go   = adv && in_reg.cmd == CMD_MIX;
    assign led_go   = adv && in_reg.cmd == CMD_LED;
    assign run      = mix_go && enabled_reg;
    assign wr_en    = adv && in_reg.cmd == CMD_WRITE
                      && 32'(in_reg.sample_index) < 32'(SAMPLE_DEPTH);

    always_comb begin
        if (32'(length_reg) < 32'(SAMPLE_DEPTH)) begin
            len = (AW + 1)'(length_reg);
        end else begin
            len = (AW + 1)'(SAMPLE_DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            v1_reg <= 1'b1;
        end else if (adv) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.cmd          <= s_tuser;
            in_reg.sample_index <= s_tdata[11:0];
            in_reg.sample_left  <= s_tdata[27:12];
            in_reg.sample_right <= s_tdata[43:28];
            in_reg.led_a        <= s_tdata[44];
            in_reg.led_b        <= s_tdata[45];
            in_reg.audio_left   <= s_tdata[61:46];
            in_reg.audio_right  <= s_tdata[77:62];
        end
    end

    tcsm_store #(
        .DEPTH (SAMPLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(in_reg.sample_index)),
        .wr_data   ({in_reg.sample_right, in_reg.sample_left}),
        .rd_addr_a (pos_a_next),
        .rd_addr_b (pos_b_next),
        .rd_data_a (frame_a),
        .rd_data_b (frame_b)
    );

    tcsm_voice #(.AW(AW)) u_voice_a (
        .run        (run),
        .volume     (volume_reg),
        .len        (len),
        .active_in  (act_a_reg),
        .pos_in     (pos_a_reg),
        .frame      (frame_a),
        .left_in    (in_reg.audio_left),
        .right_in   (in_reg.audio_right),
        .left_out   (l_mid),
        .right_out  (r_mid),
        .active_out (act_a_mix),
        .pos_out    (pos_a_mix)
    );

    tcsm_voice #(.AW(AW)) u_voice_b (
        .run        (run),
        .volume     (volume_reg),
        .len        (len),
        .active_in  (act_b_reg),
        .pos_in     (pos_b_reg),
        .frame      (frame_b),
        .left_in    (l_mid),
        .right_in   (r_mid),
        .left_out   (l_fin),
        .right_out  (r_fin),
        .active_out (act_b_mix),
        .pos_out    (pos_b_mix)
    );

    always_comb begin
        act_a_next = act_a_mix;
        pos_a_next = pos_a_mix;
        act_b_next = act_b_mix;
        pos_b_next = pos_b_mix;
        if (led_go) begin
            act_a_next = act_a_reg;
            pos_a_next = pos_a_reg;
            act_b_next = act_b_reg;
            pos_b_next = pos_b_reg;
            if (in_reg.led_a && !prev_a_reg) begin
                act_a_next = 1'b1;
                pos_a_next = '0;
            end
            if (in_reg.led_b && !prev_b_reg) begin
                act_b_next = 1'b1;
                pos_b_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_a_reg  <= 1'b0;
            act_b_reg  <= 1'b0;
            pos_a_reg  <= '0;
            pos_b_reg  <= '0;
            prev_a_reg <= 1'b0;
            prev_b_reg <= 1'b0;
        end else begin
            act_a_reg <= act_a_next;
            act_b_reg <= act_b_next;
            pos_a_reg <= pos_a_next;
            pos_b_reg <= pos_b_next;
            if (led_go) begin
                prev_a_reg <= in_reg.led_a;
                prev_b_reg <= in_reg.led_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (mix_go) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mix_go) begin
            out_l_reg  <= l_fin;
            out_r_reg  <= r_fin;
            busy_a_reg <= act_a_next;
            busy_b_reg <= act_b_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, busy_b_reg, busy_a_reg, out_r_reg, out_l_reg};

    `TCSM_ASSERT_IMP(a_idle_a_at_zero, !act_a_reg, pos_a_reg == '0)
    `TCSM_ASSERT_IMP(a_idle_b_at_zero, !act_b_reg, pos_b_reg == '0)
    `TCSM_ASSERT_NXT(a_mix_gives_result, mix_go, m_tvalid)
    `TCSM_ASSERT_NXT(a_disabled_freeze, mix_go && !enabled_reg,
        $stable(pos_a_reg) && $stable(act_a_reg) && $stable(pos_b_reg) && $stable(act_b_reg))

endmodule

### test/click_mix_monitor.sv
`timescale 1ns / 1ps

module click_mix_monitor
    import tcsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatches,
    output int          frames_pending
);

    localparam int STORE_DEPTH = 4096;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               busy_a;
        logic               busy_b;
    } mixed_frame_t;

    logic [31:0]  click_store [STORE_DEPTH];
    int unsigned  voice_pos [2];
    logic         voice_on [2];
    logic         led_seen [2];
    logic         mix_en;
    logic [8:0]   mix_volume;
    logic [12:0]  play_length;
    mixed_frame_t frames_due [$];
    int           error_count;

    initial begin
        error_count = 0;
        foreach (click_store[i]) click_store[i] = '0;
    end

    function automatic int clamp16(input int v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    task automatic field_check(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic absorb_request(input logic [1:0] code, input logic [79:0] d);
        logic         led [2];
        int           l;
        int           r;
        int           sl;
        int           sr;
        int unsigned  span;
        logic [31:0]  word;
        mixed_frame_t frame;
        case (cmd_t'(code))
            CMD_WRITE: begin
                click_store[d[11:0]] = {d[43:28], d[27:12]};
            end
            CMD_LED: begin
                led[0] = d[44];
                led[1] = d[45];
                for (int v = 0; v < 2; v++) begin
                    if (led[v] && !led_seen[v]) begin
                        voice_on[v] = 1'b1;
                        voice_pos[v] = 0;
                    end
                    led_seen[v] = led[v];
                end
            end
            CMD_MIX: begin
                l = int'($signed(d[61:46]));
                r = int'($signed(d[77:62]));
                if (mix_en) begin
                    span = (play_length < STORE_DEPTH) ? play_length : STORE_DEPTH;
                    for (int v = 0; v < 2; v++) begin
                        if (!voice_on[v]) continue;
                        if (voice_pos[v] < span) begin
                            word = click_store[voice_pos[v]];
                            sl = int'($signed(word[15:0]));
                            sr = int'($signed(word[31:16]));
                            l = clamp16(l + ((sl * int'(mix_volume)) >>> VOL_SHIFT));
                            r = clamp16(r + ((sr * int'(mix_volume)) >>> VOL_SHIFT));
                            voice_pos[v]++;
                        end
                        if (voice_pos[v] >= span) begin
                            voice_on[v] = 1'b0;
                            voice_pos[v] = 0;
                        end
                    end
                end
                frame.left = l[15:0];
                frame.right = r[15:0];
                frame.busy_a = voice_on[0];
                frame.busy_b = voice_on[1];
                frames_due.push_back(frame);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        mixed_frame_t want;
        if (!aresetn) begin
            mix_en = ENABLED_RESET;
            mix_volume = VOLUME_RESET;
            play_length = LENGTH_RESET;
            for (int v = 0; v < 2; v++) begin
                voice_pos[v] = 0;
                voice_on[v] = 1'b0;
                led_seen[v] = 1'b0;
            end
            frames_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ENABLED:       mix_en = cfg_data[0];
                    CFG_VOLUME:        mix_volume = cfg_data[8:0];
                    CFG_SAMPLE_LENGTH: play_length = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = frames_due.pop_front();
                    field_check("out_left", want.left, $signed(m_tdata[15:0]));
                    field_check("out_right", want.right, $signed(m_tdata[31:16]));
                    field_check("voice_a_busy", want.busy_a, m_tdata[32]);
                    field_check("voice_b_busy", want.busy_b, m_tdata[33]);
                end
            end
            if (s_tvalid && s_tready) absorb_request(s_tuser, s_tdata);
        end
        frames_pending <= frames_due.size();
        mismatches <= error_count;
    end

endmodule

### test/tb_triggered_click_sample_mixer_top.sv
`timescale 1ns / 1ps

module tb_triggered_click_sample_mixer_top;
    import tcsm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STORE_DEPTH = 4096;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 50;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    int   mismatches;
    int   frames_pending;
    int   tx_idle_pct;
    int   rx_stall_pct;

    // Stimulus bookkeeping that keeps every voice read inside written entries.
    bit          click_written [STORE_DEPTH];
    int          written_prefix;
    logic        led_state [2];
    int          frames_since_edge [2];
    logic        mix_on;
    logic [12:0] length_setting;

    int phase_en [RANDOM_PHASES]  = '{1, 1, 0, 1, 1, 1, 1, 1};
    int phase_vol [RANDOM_PHASES] = '{511, 0, 128, 200, 256, 77, 300, 0};
    int phase_len [RANDOM_PHASES] = '{8, 3, 5, 4096, 8191, 1, 0, 0};
    int phase_tx [RANDOM_PHASES]  = '{0, 47, 0, 34, 0, 47, 0, 34};
    int phase_rx [RANDOM_PHASES]  = '{0, 0, 47, 34, 0, 0, 47, 34};

    triggered_click_sample_mixer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    click_mix_monitor mix_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .frames_pending(frames_pending)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [15:0] pick16();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) return 16'h7FFF;
        if (roll == 1) return 16'h8000;
        return 16'($urandom);
    endfunction

    task automatic send_request(input logic [1:0] code, input logic [79:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= code;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input logic [1:0] code, input logic [11:0] idx,
                               input logic [15:0] sl, input logic [15:0] sr,
                               input logic la, input logic lb,
                               input logic [15:0] al, input logic [15:0] ar);
        int eff_len;
        if (code == CMD_MIX && mix_on) begin
            // A voice that could run past the written entries is restarted first.
            eff_len = (length_setting > STORE_DEPTH) ? STORE_DEPTH : length_setting;
            for (int v = 0; v < 2; v++) begin
                if (frames_since_edge[v] >= written_prefix && eff_len > written_prefix) begin
                    if (led_state[v])
                        send_fields(CMD_LED, 12'($urandom), 16'($urandom), 16'($urandom),
                                    (v == 0) ? 1'b0 : led_state[0],
                                    (v == 1) ? 1'b0 : led_state[1],
                                    16'($urandom), 16'($urandom));
                    send_fields(CMD_LED, 12'($urandom), 16'($urandom), 16'($urandom),
                                (v == 0) ? 1'b1 : led_state[0],
                                (v == 1) ? 1'b1 : led_state[1],
                                16'($urandom), 16'($urandom));
                end
            end
        end
        send_request(code, {2'b00, ar, al, lb, la, sr, sl, idx});
        case (code)
            CMD_WRITE: begin
                click_written[idx] = 1'b1;
                while (written_prefix < STORE_DEPTH && click_written[written_prefix])
                    written_prefix++;
            end
            CMD_LED: begin
                if (la && !led_state[0]) frames_since_edge[0] = 0;
                if (lb && !led_state[1]) frames_since_edge[1] = 0;
                led_state[0] = la;
                led_state[1] = lb;
            end
            CMD_MIX: begin
                if (mix_on) begin
                    frames_since_edge[0]++;
                    frames_since_edge[1]++;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic program_mixer(input logic en, input logic [8:0] vol,
                                 input logic [12:0] len);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ENABLED;
        cfg_data <= {12'd0, en};
        @(posedge aclk);
        cfg_index <= CFG_VOLUME;
        cfg_data <= {4'd0, vol};
        @(posedge aclk);
        cfg_index <= CFG_SAMPLE_LENGTH;
        cfg_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mix_on = en;
        length_setting = len;
    endtask

    initial begin
        #2000000;
        $display("tb_triggered_click_sample_mixer_top NOT OK");
        $finish;
    end

    initial begin
        int roll;
        int en;
        int vol;
        int len;
        logic [11:0] idx;
        logic [1:0] code;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ENABLED;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        m_tready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        written_prefix = 0;
        led_state = '{1'b0, 1'b0};
        frames_since_edge = '{0, 0};
        mix_on = ENABLED_RESET;
        length_setting = LENGTH_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings have a zero length, so triggered voices stop without adding.
        send_fields(CMD_WRITE, 12'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0);
        send_fields(CMD_WRITE, 12'd1, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        send_fields(CMD_WRITE, 12'd2, 16'hFFFF, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0);
        send_fields(CMD_WRITE, 12'd3, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'h0, 16'h0);
        send_fields(CMD_WRITE, 12'hFFF, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 16'h0, 16'h0);
        send_fields(CMD_UNUSED, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                    16'hFFFF, 16'hFFFF);
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h7FFF, 16'h8000);
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0);

        // Full gain over a short click: saturation, overlap and a restart mid-play.
        program_mixer(1'b1, 9'd256, 13'd4);
        tx_idle_pct = 34;
        rx_stall_pct = 34;
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b1, 1'b0, 16'h0, 16'h0);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b0, 16'h7FFF, 16'h7FFF);
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h8000, 16'h8000);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b0, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_LED, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'd100, 16'hFF9C);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'hFFFF, 16'h0001);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);
        send_fields(CMD_MIX, 12'd0, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0, 16'h0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            en = phase_en[p];
            vol = phase_vol[p];
            len = phase_len[p];
            if (p == RANDOM_PHASES - 1) begin
                vol = $urandom_range(511);
                len = $urandom_range(40, 2);
            end
            program_mixer(en[0], vol[8:0], len[12:0]);
            tx_idle_pct = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) code = CMD_MIX;
                else if (roll < 70) code = CMD_LED;
                else if (roll < 95) code = CMD_WRITE;
                else code = CMD_UNUSED;
                idx = 12'($urandom);
                if (code == CMD_WRITE && written_prefix < STORE_DEPTH
                        && $urandom_range(9) < 7)
                    idx = written_prefix[11:0];
                send_fields(code, idx, pick16(), pick16(), 1'($urandom), 1'($urandom),
                            pick16(), pick16());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && frames_pending == 0) begin
            $display("tb_triggered_click_sample_mixer_top OK");
        end else begin
            $display("tb_triggered_click_sample_mixer_top NOT OK");
        end
        $finish;
    end

endmodule
